// ----- src/multichannel_fir_filter_macros.svh -----
// Assertion macros shared by the filter RTL.
// No dependencies; taken in by `include in the files that assert.
`ifndef MULTICHANNEL_FIR_FILTER_MACROS_SVH
`define MULTICHANNEL_FIR_FILTER_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst
`define MCFIR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("filter assertion failed");

// Next-cycle implication, checked on clk, off during rst
`define MCFIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("filter assertion failed");

`endif

// ----- src/mcfir_pkg.sv -----
// Shared constants, types and the coefficient table of the multichannel FIR filter.
// No dependencies.
package mcfir_pkg;

  localparam int TAPS_DEF        = 81;
  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int CHANNEL_W       = 2;
  localparam int COEF_W          = 32;
  localparam int FRAC_BITS       = 31;
  localparam int ROM_LEN         = 81;
  localparam int ROM_HALF        = 41;

  // First half of the symmetric Q1.31 low-pass response, centre tap last
  localparam logic signed [COEF_W-1:0] ROM_HALF_TAB [ROM_HALF] = '{
    -32'sd11, -32'sd4387, 32'sd59, 32'sd19321, -32'sd1850, -32'sd59356, 32'sd460,
    32'sd149667, -32'sd986, -32'sd331142, 32'sd1899, 32'sd665548, -32'sd3357,
    -32'sd1240936, 32'sd5539, 32'sd2176964, -32'sd8614, -32'sd3630196, 32'sd12723,
    32'sd5800133, -32'sd17946, -32'sd8938114, 32'sd24276, 32'sd13363910,
    -32'sd31600, -32'sd19500211, 32'sd39681, 32'sd27947552, -32'sd48170,
    -32'sd39653716, 32'sd56620, 32'sd56325574, -32'sd64523, -32'sd81565861,
    32'sd71357, 32'sd124756602, -32'sd76639, -32'sd220486878, 32'sd79979,
    32'sd681076001, 32'sd1073660702
  };

  // Control passed from the sequencer to the MAC alongside each read
  typedef struct packed {
    logic valid;   // read data arrives alongside and is to be summed
    logic clear;   // start a new sum
    logic tap_ok;  // tap holds a written sample, else it counts as zero
  } mac_issue_t;

  typedef struct packed {
    logic busy;    // products still on their way into the sum
  } mac_status_t;

  // Coefficient of tap i; taps past the table are zero
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [7:0] i);
    logic [7:0] mirror;
    logic signed [COEF_W-1:0] c;
    mirror = 8'(ROM_LEN - 1) - i;
    if (i >= 8'(ROM_LEN)) begin
      c = '0;
    end else if (i < 8'(ROM_HALF)) begin
      c = ROM_HALF_TAB[i[5:0]];
    end else begin
      c = ROM_HALF_TAB[mirror[5:0]];
    end
    return c;
  endfunction

endpackage

// ----- src/mcfir_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mcfir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mcfir_mac.sv -----
// Shared multiply-accumulate unit of the filter: one tap product per cycle.
// Depends on mcfir_pkg.
module mcfir_mac import mcfir_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_W       = SAMPLE_BITS + COEF_W + 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mac_issue_t                    issue,
  input  logic        [SAMPLE_BITS-1:0] sample,
  input  logic signed [COEF_W-1:0]      coef,
  output logic signed [ACC_W-1:0]       acc,
  output mac_status_t                   status
);

  localparam int PROD_W = SAMPLE_BITS + COEF_W;

  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [PROD_W-1:0]      prod;
  logic                          prod_valid;

  assign smp         = $signed(sample);
  assign status.busy = issue.valid | prod_valid;

  // Track whether the product register holds a live term
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= issue.valid;
    end
  end

  // Multiply, then add the registered product into the sum
  always_ff @(posedge clk) begin
    if (issue.tap_ok) begin
      prod <= PROD_W'(smp) * PROD_W'(coef);
    end else begin
      prod <= '0;
    end
    if (issue.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// ----- src/multichannel_fir_filter.sv -----
// Multichannel FIR filter: one shared MAC sweeps a channel's delay ring per sample.
// A new sample is taken only in the idle state, so each sweep ends before the next one starts.
// The sweep reads one tap per cycle from the ring RAM.
// A sample on a channel past CHANNELS gives zero and leaves every ring and pointer unchanged.
// Reset (rst, synchronous) empties every ring through per-channel fill counts; no sweep.
// Depends on mcfir_pkg, mcfir_ram, mcfir_mac and multichannel_fir_filter_macros.svh.
`include "multichannel_fir_filter_macros.svh"

module multichannel_fir_filter import mcfir_pkg::*; #(
  parameter int TAPS        = TAPS_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_W-1:0]    s_tdata,   // sample_in
  input  logic [CHANNEL_W-1:0] s_tuser,   // channel
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata    // sample_out
);

  localparam int IDX_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FILL_W   = $clog2(TAPS + 1);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH    = CHANNELS * TAPS;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W    = SAMPLE_BITS + COEF_W + FILL_W;
  localparam int TOP_LSB  = FRAC_BITS + SAMPLE_BITS - 1;

  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

  state_t                   state;
  logic [IDX_W-1:0]         wp   [CHANNELS];
  logic [FILL_W-1:0]        fill [CHANNELS];
  logic [AW-1:0]            base;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         tap;
  logic [FILL_W-1:0]        fill_cur;
  logic signed [COEF_W-1:0] coef_q;
  logic [SAMPLE_BITS-1:0]   sample_q;
  mac_issue_t               issue;
  mac_status_t              mac_status;

  logic                     ch_ok;
  logic [CH_IDX_W-1:0]      ch_idx;
  logic [IDX_W-1:0]         wp_cur;
  logic [FILL_W-1:0]        fill_sel;
  logic [FILL_W-1:0]        fill_next;
  logic [AW-1:0]            base_next;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [AW-1:0]            ram_raddr;
  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-TOP_LSB-1:0] acc_top;
  logic                     acc_fits;
  logic [SAMPLE_BITS-1:0]   sat;

  // Decode the incoming channel and its ring position
  assign ch_ok     = 5'(s_tuser) < 5'(CHANNELS);
  assign ch_idx    = CH_IDX_W'(s_tuser);
  assign wp_cur    = wp[ch_idx];
  assign fill_sel  = fill[ch_idx];
  assign fill_next = (fill_sel == FILL_W'(TAPS)) ? fill_sel : fill_sel + 1'b1;
  assign base_next = AW'(32'(ch_idx) * 32'(TAPS));

  // Ring write on transfer, tap reads while running
  assign s_tready  = (state == ST_IDLE);
  assign ram_we    = s_tvalid && s_tready && ch_ok;
  assign ram_waddr = base_next + AW'(wp_cur);
  assign ram_raddr = base + AW'(idx);

  mcfir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata[SAMPLE_BITS-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mcfir_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .sample (ram_rdata),
    .coef   (coef_q),
    .acc    (acc),
    .status (mac_status)
  );

  // Drop the fraction and saturate to the sample range
  assign acc_top  = acc[ACC_W-1:TOP_LSB];
  assign acc_fits = (&acc_top) || !(|acc_top);
  assign sat      = acc_fits ? acc[TOP_LSB:FRAC_BITS] : (acc[ACC_W-1] ? SAT_MIN : SAT_MAX);

  assign m_tdata = DATA_W'(sample_q);

  // Sequencer, ring pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      issue    <= '0;
      tap      <= '0;
      idx      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp[c]   <= '0;
        fill[c] <= '0;
      end
    end else begin
      // Load the output register, or clear it once taken
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        sample_q <= sat;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          issue <= '{valid: 1'b0, clear: s_tvalid, tap_ok: 1'b0};
          if (s_tvalid) begin
            if (ch_ok) begin
              wp[ch_idx]   <= (wp_cur == '0) ? IDX_W'(TAPS - 1) : wp_cur - 1'b1;
              fill[ch_idx] <= fill_next;
              fill_cur     <= fill_next;
              base         <= base_next;
              idx          <= wp_cur;
              tap          <= '0;
              state        <= ST_RUN;
            end else begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_RUN: begin
          issue  <= '{valid: 1'b1, clear: 1'b0, tap_ok: (FILL_W'(tap) < fill_cur)};
          coef_q <= coef_at(8'(tap));
          tap    <= tap + 1'b1;
          idx    <= (idx == IDX_W'(TAPS - 1)) ? '0 : idx + 1'b1;
          if (tap == IDX_W'(TAPS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          issue <= '0;
          if (!mac_status.busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          issue <= '0;
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          issue <= '0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MCFIR_ASSERT_IMPL(a_write_idle, ram_we, s_tready)
  `MCFIR_ASSERT_IMPL(a_idle_empty, s_tready, !mac_status.busy)
  `MCFIR_ASSERT_IMPL(a_tap_range, state == ST_RUN, tap <= IDX_W'(TAPS - 1))
  `MCFIR_ASSERT_NEXT(a_result_load, (state == ST_DONE) && (!m_tvalid || m_tready), m_tvalid && (state == ST_IDLE))

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for multichannel_fir_filter: predicts each filtered sample
// and compares it with every result transfer. Depends on mcfir_pkg and the filter RTL.
module testbench import mcfir_pkg::*;;

  localparam int SW          = SAMPLE_BITS_DEF;
  localparam int DATA_W      = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 120;
  localparam int LONG_HOLD   = 800;

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam longint OUT_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  // First half of the symmetric Q1.31 low-pass response, centre tap last
  localparam int WEIGHT_HALF [41] = '{
    -11, -4387, 59, 19321, -1850, -59356, 460, 149667,
    -986, -331142, 1899, 665548, -3357, -1240936, 5539, 2176964,
    -8614, -3630196, 12723, 5800133, -17946, -8938114, 24276, 13363910,
    -31600, -19500211, 39681, 27947552, -48170, -39653716, 56620, 56325574,
    -64523, -81565861, 71357, 124756602, -76639, -220486878, 79979, 681076001,
    1073660702
  };

  typedef enum int {
    WAVE_UNIFORM,
    WAVE_FULL_SCALE,
    WAVE_QUIET,
    WAVE_TAP_SIGNS
  } wave_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata = '0;   // sample_in
  logic [CHANNEL_W-1:0] s_tuser = '0;   // channel
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DATA_W-1:0]    m_tdata;        // sample_out

  // Predictor state: one delay ring and head pointer per channel
  logic signed [SW-1:0] ring_state [CHANNELS_DEF][TAPS_DEF];
  int unsigned          ring_head [CHANNELS_DEF];

  logic signed [SW-1:0] filtered_queue [$];
  logic signed [SW-1:0] want_out;
  int                   fail_count = 0;
  int                   cycle_count = 0;
  int                   rx_hold = 0;
  int                   rx_stall = 0;
  logic                 tx_idle = 1'b1;
  logic                 rx_idle = 1'b1;

  multichannel_fir_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // sample_in
    .s_tuser  (s_tuser),   // channel
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // sample_out
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int tap_weight(input int i);
    return (i < ROM_HALF) ? WEIGHT_HALF[i] : WEIGHT_HALF[ROM_LEN - 1 - i];
  endfunction

  // Write the sample into its ring, convolve, floor-shift and saturate
  function automatic logic signed [SW-1:0] filter_predict(input logic [CHANNEL_W-1:0] ch,
                                                          input logic signed [SW-1:0] x);
    int unsigned head;
    int unsigned idx;
    longint      acc;
    longint      q;
    head = ring_head[ch];
    ring_state[ch][head] = x;
    acc = 0;
    idx = head;
    for (int i = 0; i < TAPS_DEF; i++) begin
      acc += longint'(ring_state[ch][idx]) * longint'(tap_weight(i));
      idx = (idx == TAPS_DEF - 1) ? 0 : idx + 1;
    end
    ring_head[ch] = (head == 0) ? TAPS_DEF - 1 : head - 1;
    q = acc >>> FRAC_BITS;
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
    end
    return q[SW-1:0];
  endfunction

  // Offer one sample; entered and left at a falling edge
  task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic signed [SW-1:0] x);
    int gap;
    gap = tx_idle ? $urandom_range(3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'($unsigned(x));
    s_tuser  <= ch;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    filtered_queue.push_back(filter_predict(ch, x));
  endtask

  // Drop valid and hold the input quiet for a number of cycles
  task automatic pause_input(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold the input until every expected result has been taken
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (filtered_queue.size() != 0) @(negedge clk);
  endtask

  // Receiver: long hold-off first, then the per-result stall
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (filtered_queue.size() == 0) begin
        $error("sample_out: no result expected, got %0d", $signed(m_tdata[SW-1:0]));
        fail_count++;
      end else begin
        want_out = filtered_queue.pop_front();
        if (m_tdata !== DATA_W'($unsigned(want_out))) begin
          $error("sample_out: expected %0d, got %0d", want_out, $signed(m_tdata[SW-1:0]));
          fail_count++;
        end
      end
      rx_stall = rx_idle ? $urandom_range(3) : 0;
    end
  end

  // Extremes and bit patterns on every channel, interleaved
  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_sample(0, SAMPLE_MAX);
    send_sample(0, SAMPLE_MIN);
    send_sample(0, '0);
    send_sample(0, -1);
    send_sample(1, 24'sh555555);
    send_sample(1, 24'shAAAAAA);
    send_sample(1, SAMPLE_MAX);
    send_sample(1, SAMPLE_MAX);
    send_sample(2, SAMPLE_MIN);
    send_sample(2, SAMPLE_MIN);
    send_sample(2, 1);
    send_sample(3, SAMPLE_MAX);
    send_sample(3, -1);
    send_sample(3, SAMPLE_MIN);
    send_sample(3, '0);
    send_sample(0, SAMPLE_MAX);
    send_sample(2, 24'sh0F0F0F);
    send_sample(1, 24'shF0F0F0);
    send_sample(3, 1);
    send_sample(0, 24'sh400000);
  endtask

  // Match every tap's sign at full scale to drive the sum past both rails
  task automatic test_saturation();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int k = 0; k < TAPS_DEF; k++) begin
      send_sample(2, (tap_weight(k) >= 0) ? SAMPLE_MAX : SAMPLE_MIN);
    end
    for (int k = 0; k < TAPS_DEF; k++) begin
      send_sample(2, (tap_weight(k) >= 0) ? SAMPLE_MIN : SAMPLE_MAX);
    end
  endtask

  // Stall the output for a long stretch while the input keeps offering
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    pause_input(1);
    @(posedge clk);
    rx_hold = LONG_HOLD;
    @(negedge clk);
    for (int k = 0; k < 12; k++) begin
      send_sample(CHANNEL_W'(k % CHANNELS_DEF), SW'($urandom));
    end
    wait_for_results();
  endtask

  // Let the block drain completely between short bursts
  task automatic test_drain_gaps();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int b = 0; b < 3; b++) begin
      for (int k = 0; k < 4; k++) begin
        send_sample(CHANNEL_W'($urandom_range(3)), SW'($urandom));
      end
      wait_for_results();
    end
  endtask

  // Bursts of random waveforms with random idling on both sides
  task automatic test_random_streams(input int item_goal);
    int                   sent;
    int                   burst;
    wave_t                wave;
    logic [CHANNEL_W-1:0] ch;
    logic                 hop;
    logic                 flip;
    logic signed [SW-1:0] x;
    sent = 0;
    while (sent < item_goal) begin
      wave    = wave_t'($urandom_range(3));
      burst   = (wave == WAVE_TAP_SIGNS) ? $urandom_range(81, 100) : $urandom_range(1, 40);
      ch      = CHANNEL_W'($urandom_range(3));
      hop     = 1'($urandom_range(1));
      flip    = 1'($urandom_range(1));
      tx_idle = ($urandom_range(3) != 0);
      rx_idle = ($urandom_range(3) != 0);
      for (int j = 0; j < burst; j++) begin
        if (hop) begin
          ch = CHANNEL_W'($urandom_range(3));
        end
        case (wave)
          WAVE_UNIFORM: begin
            x = SW'($urandom);
          end
          WAVE_FULL_SCALE: begin
            x = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
          end
          WAVE_QUIET: begin
            x = SW'(int'($urandom_range(511)) - 256);
          end
          default: begin
            x = ((tap_weight(j % TAPS_DEF) >= 0) ^ flip) ? SAMPLE_MAX : SAMPLE_MIN;
          end
        endcase
        send_sample(ch, x);
        sent++;
      end
    end
  endtask

  initial begin
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      ring_head[c] = 0;
      for (int t = 0; t < TAPS_DEF; t++) begin
        ring_state[c][t] = '0;
      end
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_saturation();
    test_backpressure();
    test_drain_gaps();
    test_random_streams(1500);

    // Drain, then allow for anything arriving late
    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (filtered_queue.size() != 0) begin
      $error("sample_out: %0d results never arrived", filtered_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/mcfir_pkg.sv
src/mcfir_ram.sv
src/mcfir_mac.sv
src/multichannel_fir_filter.sv
tb/testbench.sv
